/* design/gx_tiled_texel_encoder_assert.svh */
// assertion macros for the tiled texel encoder
// every property is sampled on clk and held off while rst is high
`ifndef GX_TILED_TEXEL_ENCODER_ASSERT_SVH
`define GX_TILED_TEXEL_ENCODER_ASSERT_SVH

// same-cycle implication
`define GXTTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gxtte assertion failed");

// next-cycle implication
`define GXTTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gxtte assertion failed");

`endif

/* design/gxtte_pkg.sv */
// ----------------------------------------------------------------------------
// gxtte_pkg
// shared types, codes and arithmetic helpers of the tiled texel encoder
// ----------------------------------------------------------------------------
package gxtte_pkg;

  localparam int unsigned MaxTiles = 256;
  localparam int unsigned TileW    = $clog2(MaxTiles) + 1;  // holds 1..MaxTiles
  localparam int unsigned CountW   = 10;                    // pixel column / row
  localparam int unsigned OffsetW  = 21;
  localparam int unsigned DataW    = 16;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDE   = 2'd1,
    REG_HIGH   = 2'd2
  } reg_index_t;

  // texel formats
  localparam logic FMT_I4     = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // write kinds
  typedef enum logic [1:0] {
    KIND_HI_NIBBLE = 2'd0,
    KIND_LO_NIBBLE = 2'd1,
    KIND_BE_HALF   = 2'd2
  } write_kind_t;

  // effective configuration, tile counts already clamped to 1..MaxTiles
  typedef struct packed {
    logic              texel_format;
    logic [TileW-1:0]  tiles_wide;
    logic [TileW-1:0]  tiles_high;
  } cfg_t;

  // raster position of one pixel
  typedef struct packed {
    logic [CountW-1:0] col;
    logic [CountW-1:0] row;
    logic              last;
  } pos_t;

  // round(c * maxv / 255), division by 255 done with the shift-add identity
  function automatic logic [5:0] scale_chan(input logic [7:0] c, input logic [5:0] maxv);
    logic [15:0] v;
    logic [15:0] q;
    v = 16'({8'd0, c} * {10'd0, maxv}) + 16'd127;
    q = (v + (v >> 8) + 16'd1) >> 8;
    return q[5:0];
  endfunction

  // top nibble of (r + g + b) / 3, using 683 / 2048 as the reciprocal
  function automatic logic [3:0] luma_nibble(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {2'd0, r} + {2'd0, g} + {2'd0, b};
    prod = {10'd0, sum} * 20'd683;
    return prod[18:15];
  endfunction

endpackage

/* design/gxtte_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gxtte_cfg_regs
// configuration registers; clamps tile counts and flags each known-index write
// ----------------------------------------------------------------------------
module gxtte_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data,
  output gxtte_pkg::cfg_t     cfg,
  output logic                restart
);
  import gxtte_pkg::*;

  logic             texel_format;
  logic [TileW-1:0] tiles_wide;
  logic [TileW-1:0] tiles_high;
  logic             known_index;

  always_comb begin
    case (cfg_index)
      REG_FORMAT, REG_WIDE, REG_HIGH: known_index = 1'b1;
      default:                        known_index = 1'b0;
    endcase
  end

  assign restart = cfg_valid && known_index;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_I4;
      tiles_wide   <= TileW'(1);
      tiles_high   <= TileW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT: texel_format <= cfg_data[0];
        REG_WIDE:   tiles_wide   <= cfg_data[TileW-1:0];
        REG_HIGH:   tiles_high   <= cfg_data[TileW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [TileW-1:0] clamp_tiles(input logic [TileW-1:0] raw);
    if (raw == '0) return TileW'(1);
    if (raw > TileW'(MaxTiles)) return TileW'(MaxTiles);
    return raw;
  endfunction

  assign cfg.texel_format = texel_format;
  assign cfg.tiles_wide   = clamp_tiles(tiles_wide);
  assign cfg.tiles_high   = clamp_tiles(tiles_high);

endmodule

/* design/gxtte_raster.sv */
// ----------------------------------------------------------------------------
// gxtte_raster
// column and row counters of the raster scan, with end-of-image detection
// ----------------------------------------------------------------------------
module gxtte_raster (
  input  logic                clk,
  input  logic                rst,
  input  gxtte_pkg::cfg_t     cfg,
  input  logic                restart,
  input  logic                advance,
  output gxtte_pkg::pos_t     pos
);
  import gxtte_pkg::*;

  logic [CountW-1:0] col;
  logic [CountW-1:0] row;
  logic [CountW-1:0] col_next;
  logic [CountW-1:0] row_next;
  logic              row_end;
  logic              col_end;

  // pixel width is tiles * 4
  assign col_end = ({1'b0, col} + (CountW+1)'(1)) >= {cfg.tiles_wide, 2'b00};
  assign row_end = ({1'b0, row} + (CountW+1)'(1)) >= {cfg.tiles_high, 2'b00};

  always_comb begin
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (advance) begin
      if (col_end) begin
        col_next = '0;
        row_next = row_end ? '0 : row + CountW'(1);
      end else begin
        col_next = col + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign pos.col  = col;
  assign pos.row  = row;
  assign pos.last = col_end && row_end;

endmodule

/* design/gxtte_texel_calc.sv */
// ----------------------------------------------------------------------------
// gxtte_texel_calc
// tiled byte offset, texel data and write kind of one registered pixel
// ----------------------------------------------------------------------------
module gxtte_texel_calc (
  input  gxtte_pkg::cfg_t     cfg,
  input  gxtte_pkg::pos_t     pos,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic [20:0]         byte_offset,
  output logic [15:0]         write_data,
  output logic [1:0]          write_kind
);
  import gxtte_pkg::*;

  logic [16:0] tile_row_base;
  logic [16:0] tile_sum;
  logic [15:0] tile;
  logic [4:0]  r5;
  logic [5:0]  g6;
  logic [4:0]  b5;
  write_kind_t kind;

  // tile index = (row / 4) * tiles_wide + col / 4
  assign tile_row_base = {9'd0, pos.row[CountW-1:2]} * {8'd0, cfg.tiles_wide};
  assign tile_sum      = tile_row_base + {9'd0, pos.col[CountW-1:2]};
  assign tile          = tile_sum[15:0];

  // rgb565 channel scaling
  assign r5 = 5'(scale_chan(red,   6'd31));
  assign g6 = scale_chan(green, 6'd63);
  assign b5 = 5'(scale_chan(blue,  6'd31));

  always_comb begin
    if (cfg.texel_format == FMT_RGB565) begin
      byte_offset = {tile, pos.row[1:0], pos.col[1:0], 1'b0};
      write_data  = {r5, g6, b5};
      kind        = KIND_BE_HALF;
    end else begin
      byte_offset = {2'd0, tile, pos.row[1:0], pos.col[1]};
      write_data  = {12'd0, luma_nibble(red, green, blue)};
      kind        = pos.col[0] ? KIND_LO_NIBBLE : KIND_HI_NIBBLE;
    end
  end

  assign write_kind = kind;

endmodule

/* design/gx_tiled_texel_encoder.sv */
// ----------------------------------------------------------------------------
// gx_tiled_texel_encoder
// raster rgb pixels in, write commands for a 4x4-tiled texture out
// ----------------------------------------------------------------------------
// Accepts one raster-order pixel per clock while the output is not stalled,
// and returns one write word per pixel, held first in the input register,
// then in the result register. The path between them is the tile-row multiply
// (row/4 times tiles_wide, 8 by 9 bits) plus the offset add. Output stalls
// hold the pipeline without dropping words; the slave side stays ready
// whenever the result register is free or being drained. Configuration
// writes are taken at any time, restart the image and should be issued
// only while the block is empty.
module gx_tiled_texel_encoder (
  input  logic        clk,
  input  logic        rst,
  // pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  // write stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // byte_offset[20:0], write_data[36:21], zero[39:37]
  output logic [1:0]  m_tuser,   // write_kind[1:0]
  output logic        m_tlast,   // last pixel of the image
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import gxtte_pkg::*;

  cfg_t        cfg;
  pos_t        pos;
  logic        restart;
  logic        in_accept;
  logic        out_load;

  logic        s1_valid;
  pos_t        s1_pos;
  logic [7:0]  s1_red;
  logic [7:0]  s1_green;
  logic [7:0]  s1_blue;

  logic [20:0] calc_offset;
  logic [15:0] calc_data;
  logic [1:0]  calc_kind;

  logic [20:0] out_offset;
  logic [15:0] out_data;

  assign cfg_ready = 1'b1;

  gxtte_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .restart   (restart)
  );

  gxtte_raster u_raster (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .advance (in_accept),
    .pos     (pos)
  );

  // handshake: result register loads when empty or being drained
  assign out_load  = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_load;
  assign in_accept = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos   <= pos;
      s1_red   <= s_tdata[7:0];
      s1_green <= s_tdata[15:8];
      s1_blue  <= s_tdata[23:16];
    end
  end

  gxtte_texel_calc u_calc (
    .cfg         (cfg),
    .pos         (s1_pos),
    .red         (s1_red),
    .green       (s1_green),
    .blue        (s1_blue),
    .byte_offset (calc_offset),
    .write_data  (calc_data),
    .write_kind  (calc_kind)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_offset <= calc_offset;
      out_data   <= calc_data;
      m_tuser    <= calc_kind;
      m_tlast    <= s1_pos.last;
    end
  end

  assign m_tdata = {3'd0, out_data, out_offset};

endmodule

/* design/gxtte_checker.sv */
// ----------------------------------------------------------------------------
// gxtte_checker
// port-level checks of the tiled texel encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "gx_tiled_texel_encoder_assert.svh"

module gxtte_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_ready
);
  import gxtte_pkg::*;

  logic stalled;
  logic nibble_word;
  logic half_word;

  assign stalled     = m_tvalid && !m_tready;
  assign nibble_word = m_tvalid && (m_tuser == KIND_HI_NIBBLE || m_tuser == KIND_LO_NIBBLE);
  assign half_word   = m_tvalid && m_tuser == KIND_BE_HALF;

  // a stalled word stays offered
  `GXTTE_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid)
  // only the three write kinds appear
  `GXTTE_ASSERT_NOW(a_kind_known, m_tvalid, nibble_word || half_word)
  // nibble writes carry four data bits, with the upper data bits and the padding zero
  `GXTTE_ASSERT_NOW(a_nibble_data, nibble_word, m_tdata[39:25] == 15'd0)
  // halfword writes land on even offsets and leave the padding zero
  `GXTTE_ASSERT_NOW(a_half_even, half_word, m_tdata[0] == 1'b0 && m_tdata[39:37] == 3'd0)
  // configuration port never stalls
  `GXTTE_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind gx_tiled_texel_encoder gxtte_checker u_gxtte_checker (.*);
